[design/pa_pkg.sv]
// primitive assembly package: mode codes, queue record type and lookup tables
// used by the front, the queue wiring in the top level and the back end
// no dependencies
`default_nettype none

package pa_pkg;

    // default handle width and queue depth for the top level parameters
    localparam int VERTEX_ID_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF    = 4;

    // results one vertex can cause, and the index width over them
    localparam int MAX_RESULTS = 4;
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);

    // vertex count wraps at twelve, a common multiple of three and four
    localparam logic [3:0] PHASE_LAST = 4'd11;

    // seen counter saturates here
    localparam logic [1:0] SEEN_MAX = 2'd3;

    // primitive mode register codes
    typedef enum logic [2:0] {
        MODE_TRIS       = 3'd0,
        MODE_QUADS      = 3'd1,
        MODE_QUAD_STRIP = 3'd2,
        MODE_LINES      = 3'd3,
        MODE_FAN        = 3'd4,
        MODE_TRI_STRIP  = 3'd5,
        MODE_LINE_STRIP = 3'd6,
        MODE_LINE_LOOP  = 3'd7
    } t_mode;

    // phase modulo three
    localparam logic [1:0] MOD3_LUT [16] = '{
        2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
        2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0
    };

    // control part of one queued job (handles travel beside it)
    typedef struct packed {
        logic [RES_IDX_W-1:0]                  last_idx;
        logic                                  has_vertex;
        logic                                  batch_end;
        logic                                  batch_error;
        logic [MAX_RESULTS-1:0][1:0]           corners;
    } t_job_ctl;

    localparam int JOB_CTL_W = $bits(t_job_ctl);

endpackage

`default_nettype wire

[design/pa_front.sv]
// primitive assembly front: holds the batch state and the mode register,
// turns each accepted vertex beat into at most one queued job of up to four corners
// depends on pa_pkg
`default_nettype none

module pa_front #(
    parameter int VERTEX_ID_BITS = 16
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_cfg_we,
    input  wire logic [2:0]                                  i_cfg_wdata,
    input  wire logic                                        i_valid,
    input  wire logic [VERTEX_ID_BITS-1:0]                   i_vertex_id,
    input  wire logic                                        i_batch_last,
    output logic                                             o_ready,
    output logic                                             o_push,
    input  wire logic                                        i_push_ready,
    output pa_pkg::t_job_ctl                                 o_job_ctl,
    output logic [pa_pkg::MAX_RESULTS-1:0][VERTEX_ID_BITS-1:0] o_job_ids
);
    import pa_pkg::*;

    t_mode                      r_mode;
    logic [VERTEX_ID_BITS-1:0]  r_first, r_prev, r_prev2;
    logic [3:0]                 r_phase, n_phase;
    logic [1:0]                 r_seen;
    logic                       r_parity, n_parity;

    logic [VERTEX_ID_BITS-1:0]  first_eff;
    logic [2:0]                 res_cnt;
    logic                       err;
    logic                       accept;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_TRIS;
        end else if (i_cfg_we) begin
            r_mode <= t_mode'(i_cfg_wdata);
        end
    end

    assign accept  = i_valid && i_push_ready;
    assign o_ready = i_push_ready;

    // classify the vertex and build its job
    always_comb begin
        o_job_ids = '0;
        o_job_ctl = '0;
        res_cnt   = 3'd0;
        err       = 1'b0;
        n_parity  = r_parity;
        first_eff = (r_seen == 2'd0) ? i_vertex_id : r_first;
        n_phase   = (r_phase >= PHASE_LAST) ? 4'd0 : r_phase + 4'd1;
        o_job_ctl.has_vertex = 1'b1;

        unique case (r_mode)
            MODE_TRIS: begin
                res_cnt              = 3'd1;
                o_job_ids[0]         = i_vertex_id;
                o_job_ctl.corners[0] = MOD3_LUT[r_phase];
                err                  = (MOD3_LUT[n_phase] != 2'd0);
            end
            MODE_QUADS: begin
                res_cnt              = 3'd1;
                o_job_ids[0]         = i_vertex_id;
                o_job_ctl.corners[0] = r_phase[1:0];
                err                  = (n_phase[1:0] != 2'd0);
            end
            MODE_QUAD_STRIP, MODE_LINES: begin
                res_cnt              = 3'd1;
                o_job_ids[0]         = i_vertex_id;
                o_job_ctl.corners[0] = {1'b0, r_phase[0]};
            end
            MODE_FAN: begin
                if (r_seen >= 2'd2) begin
                    res_cnt              = 3'd3;
                    o_job_ids[0]         = first_eff;
                    o_job_ids[1]         = r_prev;
                    o_job_ids[2]         = i_vertex_id;
                    o_job_ctl.corners[0] = 2'd0;
                    o_job_ctl.corners[1] = 2'd1;
                    o_job_ctl.corners[2] = 2'd2;
                end
            end
            MODE_TRI_STRIP: begin
                if (r_seen >= 2'd2) begin
                    res_cnt              = 3'd3;
                    o_job_ids[0]         = r_parity ? r_prev : r_prev2;
                    o_job_ids[1]         = r_parity ? r_prev2 : r_prev;
                    o_job_ids[2]         = i_vertex_id;
                    o_job_ctl.corners[0] = 2'd0;
                    o_job_ctl.corners[1] = 2'd1;
                    o_job_ctl.corners[2] = 2'd2;
                    n_parity             = !r_parity;
                end
            end
            MODE_LINE_STRIP, MODE_LINE_LOOP: begin
                if (r_seen >= 2'd1) begin
                    res_cnt              = 3'd2;
                    o_job_ids[0]         = r_prev;
                    o_job_ids[1]         = i_vertex_id;
                    o_job_ctl.corners[0] = 2'd0;
                    o_job_ctl.corners[1] = 2'd1;
                    // closing pair of a loop
                    if (r_mode == MODE_LINE_LOOP && i_batch_last) begin
                        res_cnt              = 3'd4;
                        o_job_ids[2]         = i_vertex_id;
                        o_job_ids[3]         = first_eff;
                        o_job_ctl.corners[2] = 2'd0;
                        o_job_ctl.corners[3] = 2'd1;
                    end
                end
            end
            default: begin
                res_cnt = 3'd0;
            end
        endcase

        // status-only beat when a batch ends with nothing to emit
        if (i_batch_last && res_cnt == 3'd0) begin
            res_cnt              = 3'd1;
            o_job_ctl.has_vertex = 1'b0;
        end

        o_job_ctl.last_idx    = RES_IDX_W'(res_cnt - 3'd1);
        o_job_ctl.batch_end   = i_batch_last;
        o_job_ctl.batch_error = i_batch_last && err;
    end

    assign o_push = accept && (res_cnt != 3'd0);

    // batch counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= 4'd0;
            r_seen   <= 2'd0;
            r_parity <= 1'b0;
        end else if (accept) begin
            if (i_batch_last) begin
                r_phase  <= 4'd0;
                r_seen   <= 2'd0;
                r_parity <= 1'b0;
            end else begin
                r_phase  <= n_phase;
                r_seen   <= (r_seen == SEEN_MAX) ? SEEN_MAX : r_seen + 2'd1;
                r_parity <= n_parity;
            end
        end
    end

    // vertex history
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_first <= first_eff;
            r_prev  <= i_vertex_id;
            r_prev2 <= r_prev;
        end
    end

endmodule

`default_nettype wire

[design/pa_queue.sv]
// primitive assembly job queue: small register fifo between front and back
// depends on pa_pkg only through the widths the top level hands down
`default_nettype none

module pa_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_not_full,
    input  wire logic             i_pop,
    output logic                  o_not_empty,
    output logic [WIDTH-1:0]      o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_not_full  = (r_count != CNT_W'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign do_push     = i_push && o_not_full;
    assign do_pop      = i_pop && o_not_empty;
    assign o_data      = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

[design/pa_back.sv]
// primitive assembly back end: walks the corners of the head job, one
// result beat per cycle unless the output stalls, into a registered output stage
// depends on pa_pkg
`default_nettype none

module pa_back #(
    parameter int VERTEX_ID_BITS = 16
) (
    input  wire logic                                             i_clk,
    input  wire logic                                             i_rst_n,
    input  wire logic                                             i_job_valid,
    input  wire pa_pkg::t_job_ctl                                 i_job_ctl,
    input  wire logic [pa_pkg::MAX_RESULTS-1:0][VERTEX_ID_BITS-1:0] i_job_ids,
    output logic                                                  o_job_pop,
    output logic                                                  o_valid,
    input  wire logic                                             i_ready,
    output logic [VERTEX_ID_BITS-1:0]                             o_vertex_id,
    output logic [1:0]                                            o_corner,
    output logic                                                  o_has_vertex,
    output logic                                                  o_last_of_run,
    output logic                                                  o_batch_end,
    output logic                                                  o_batch_error
);
    import pa_pkg::*;

    logic [RES_IDX_W-1:0]      r_idx;
    logic                      r_valid;
    logic [VERTEX_ID_BITS-1:0] r_vertex_id;
    logic [1:0]                r_corner;
    logic                      r_has_vertex, r_last_of_run, r_batch_end, r_batch_error;
    logic                      out_free, load, at_last;

    assign out_free  = !r_valid || i_ready;
    assign load      = i_job_valid && out_free;
    assign at_last   = (r_idx == i_job_ctl.last_idx);
    assign o_job_pop = load && at_last;

    // corner index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_valid <= i_job_valid;
            end
            if (load) begin
                r_idx <= at_last ? '0 : r_idx + RES_IDX_W'(1);
            end
        end
    end

    // output beat payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_vertex_id   <= i_job_ids[r_idx];
            r_corner      <= i_job_ctl.corners[r_idx];
            r_has_vertex  <= i_job_ctl.has_vertex;
            r_last_of_run <= at_last;
            r_batch_end   <= at_last && i_job_ctl.batch_end;
            r_batch_error <= at_last && i_job_ctl.batch_error;
        end
    end

    assign o_valid       = r_valid;
    assign o_vertex_id   = r_vertex_id;
    assign o_corner      = r_corner;
    assign o_has_vertex  = r_has_vertex;
    assign o_last_of_run = r_last_of_run;
    assign o_batch_end   = r_batch_end;
    assign o_batch_error = r_batch_error;

endmodule

`default_nettype wire

[design/primitive_assembly.sv]
// primitive assembly top level: stream ports, front, job queue and back end
// depends on pa_pkg, pa_front, pa_queue, pa_back
//
// usage
//  - slave stream: one vertex handle per beat in tdata, tlast on the last
//    vertex of a batch
//  - master stream: one corner (or one status beat) per beat; tlast marks the
//    final beat caused by one input vertex, tuser carries has_vertex,
//    batch_end and batch_error
//  - i_cfg_we/i_cfg_wdata write the 3-bit primitive mode; write it only while
//    no batch is in flight
//  - the result beats of a vertex pass the queue write, then the output
//    register, before they are valid on the master stream
//  - throughput: the back end gives one result beat per cycle unless stalled;
//    a fan or triangle strip vertex gives 3 beats, a line strip or loop
//    vertex 2, a loop's last vertex 4, a pass-through or status beat 1, others 0
//  - the front takes one vertex per cycle while the job queue (QUEUE_DEPTH
//    jobs) has room
//  - reset sets the mode to triangles, clears the batch counters, empties the
//    queue and drops o_m_tvalid
//  - when the receiver stalls the output beat holds, the queue fills and then
//    o_s_tready falls
`default_nettype none

module primitive_assembly #(
    parameter int VERTEX_ID_BITS = pa_pkg::VERTEX_ID_BITS_DEF,
    parameter int QUEUE_DEPTH    = pa_pkg::QUEUE_DEPTH_DEF,
    localparam int IN_TDATA_W    = ((VERTEX_ID_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W   = ((VERTEX_ID_BITS + 2 + 7) / 8) * 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration
    input  wire logic                   i_cfg_we,
    input  wire logic [2:0]             i_cfg_wdata,
    // vertex input
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,   // vertex_id, zero pad
    input  wire logic                   i_s_tlast,
    // corner output
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,   // out_vertex_id, corner, zero pad
    output logic                        o_m_tlast,
    output logic [2:0]                  o_m_tuser    // has_vertex, batch_end, batch_error
);
    import pa_pkg::*;

    localparam int JOB_W = JOB_CTL_W + MAX_RESULTS * VERTEX_ID_BITS;

    t_job_ctl                                  push_ctl, pop_ctl;
    logic [MAX_RESULTS-1:0][VERTEX_ID_BITS-1:0] push_ids, pop_ids;
    logic [JOB_W-1:0]                          push_data, pop_data;
    logic                                      push, q_not_full, q_not_empty, pop;
    logic [VERTEX_ID_BITS-1:0]                 out_vid;
    logic [1:0]                                out_corner;
    logic                                      out_has, out_bend, out_berr;

    // front: state and classification
    pa_front #(
        .VERTEX_ID_BITS (VERTEX_ID_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_s_tvalid),
        .i_vertex_id  (i_s_tdata[VERTEX_ID_BITS-1:0]),
        .i_batch_last (i_s_tlast),
        .o_ready      (o_s_tready),
        .o_push       (push),
        .i_push_ready (q_not_full),
        .o_job_ctl    (push_ctl),
        .o_job_ids    (push_ids)
    );

    assign push_data = {push_ctl, push_ids};

    // job queue
    pa_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      (push_data),
        .o_not_full  (q_not_full),
        .i_pop       (pop),
        .o_not_empty (q_not_empty),
        .o_data      (pop_data)
    );

    assign pop_ctl = t_job_ctl'(pop_data[JOB_W-1 -: JOB_CTL_W]);
    assign pop_ids = pop_data[MAX_RESULTS*VERTEX_ID_BITS-1:0];

    // back end: corner sequencing and output register
    pa_back #(
        .VERTEX_ID_BITS (VERTEX_ID_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (q_not_empty),
        .i_job_ctl     (pop_ctl),
        .i_job_ids     (pop_ids),
        .o_job_pop     (pop),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_vertex_id   (out_vid),
        .o_corner      (out_corner),
        .o_has_vertex  (out_has),
        .o_last_of_run (o_m_tlast),
        .o_batch_end   (out_bend),
        .o_batch_error (out_berr)
    );

    // output beat packing
    assign o_m_tdata = OUT_TDATA_W'({out_corner, out_vid});
    assign o_m_tuser = {out_berr, out_bend, out_has};

    // batch end only on the final beat of a vertex
    a_bend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> o_m_tlast)
        else $error("batch end flagged on a beat that is not last of run");

    // a status-only beat always closes a batch
    a_status_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tuser[1] && o_m_tlast))
        else $error("status-only beat without batch end");

    // error is reported only at batch end
    a_err_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[2]) |-> o_m_tuser[1])
        else $error("batch error outside batch end");

    // a pushed job enters a queue that has room
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> q_not_full)
        else $error("job pushed into a full queue");

endmodule

`default_nettype wire
